### rtl/core/ccpd_pkg.sv
// ----------------------------------------------------------------------------
// ccpd_pkg
// Shared types and codes for the cloud-in-cell deposit and projection block.
// ----------------------------------------------------------------------------
package ccpd_pkg;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [5:0]         pixel_col;
    logic [5:0]         pixel_row;
  } req_t;

  typedef struct packed {
    logic [35:0] column_sum;
    logic [3:0]  voxels_written;
    logic        saturated;
  } rsp_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_SCALE_X  = 3'd3;
  localparam logic [2:0] REG_SCALE_Y  = 3'd4;
  localparam logic [2:0] REG_SCALE_Z  = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [31:0] VOX_MAX = 32'hFFFF_FFFF;
  localparam logic [35:0] SUM_MAX = 36'hF_FFFF_FFFF;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NORM,
    ST_DIFF,
    ST_MLO,
    ST_MHI,
    ST_SUM,
    ST_QUANT,
    ST_WRAP_WAIT,
    ST_VW1,
    ST_VW2,
    ST_VA1,
    ST_VA2,
    ST_VA3,
    ST_VWR,
    ST_RD_ISSUE,
    ST_RD_ACC,
    ST_DONE
  } state_t;

endpackage

### rtl/core/ccpd_mem.sv
// ----------------------------------------------------------------------------
// ccpd_mem
// Density voxel store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ccpd_mem #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic                clk,
  input  ccpd_pkg::mem_ctl_t  ctl,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [31:0]         wr_data,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [31:0]         rd_data
);
  import ccpd_pkg::*;

  logic [31:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

### rtl/core/ccpd_wrap.sv
// ----------------------------------------------------------------------------
// ccpd_wrap
// Iterative true modulo of a signed value by a constant, four bits a cycle.
// ----------------------------------------------------------------------------
module ccpd_wrap #(
  parameter int MODULUS = 64,
  parameter int IN_W    = 36
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [IN_W-1:0]     value,
  output logic                       done,
  output logic [$clog2(MODULUS)-1:0] result
);
  import ccpd_pkg::*;

  localparam int STEP  = 4;
  localparam int NSTEP = IN_W / STEP;
  localparam int CW    = $clog2(NSTEP + 1);
  localparam int OW    = $clog2(MODULUS);
  localparam int RW    = OW + 1;

  // 2^n mod m by repeated doubling
  function automatic int pow2mod(input int n, input int m);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = 2 * r;
      if (r >= m) r = r - m;
    end
    return r;
  endfunction

  localparam logic [RW-1:0] MOD_V = RW'(MODULUS);
  localparam logic [RW-1:0] WRAP_C = RW'(pow2mod(IN_W, MODULUS));

  logic [IN_W-1:0] shreg;
  logic [RW-1:0]   rem;
  logic [CW-1:0]   cnt;
  logic            neg;
  logic            run;
  logic [RW-1:0]   rem_next;
  logic [RW:0]     fix;

  always_comb begin
    rem_next = rem;
    for (int i = 0; i < STEP; i++) begin
      rem_next = {rem_next[RW-2:0], shreg[IN_W-1-i]};
      if (rem_next >= MOD_V) rem_next = rem_next - MOD_V;
    end
  end

  // a negative value was taken as value + 2^IN_W; remove that offset
  always_comb begin
    if (!neg) begin
      fix = {1'b0, rem};
    end else if (rem >= WRAP_C) begin
      fix = {1'b0, rem} - {1'b0, WRAP_C};
    end else begin
      fix = {1'b0, rem} + {1'b0, MOD_V} - {1'b0, WRAP_C};
    end
  end

  assign result = fix[OW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        shreg <= value;
        rem   <= '0;
        neg   <= value[IN_W-1];
        cnt   <= CW'(NSTEP);
        run   <= 1'b1;
      end else if (run) begin
        shreg <= shreg << STEP;
        rem   <= rem_next;
        cnt   <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/cic_particle_deposit_projection.sv
// ----------------------------------------------------------------------------
// cic_particle_deposit_projection
// Cloud-in-cell particle deposit into a 3-D density store, with read-and-clear
// projection of one pixel column over depth.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+-------------------
//  request   | req (req_t)                               | start & !busy
//  result    | result (rsp_t)                            | result_valid, 1 cycle
//  config    | psel penable pwrite paddr pwdata prdata   | APB, pready tied 1
//
//  Deposit: a scaling multiply per axis, a wait on the z wrap unit, then a
//  read-modify-write of the store per voxel.
//  Readout: one read and one clear per depth slice.
//  After reset a clearing pass writes zero to all GRID_WIDTH*GRID_ROWS*
//  GRID_DEPTH voxels, one a cycle, with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module cic_particle_deposit_projection #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_ROWS   = 64,
  parameter int GRID_DEPTH  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ccpd_pkg::req_t   req,
  output logic             result_valid,
  output ccpd_pkg::rsp_t   result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ccpd_pkg::*;

  localparam int NVOX   = GRID_WIDTH * GRID_ROWS * GRID_DEPTH;
  localparam int ADDR_W = $clog2(NVOX);
  localparam int XW     = $clog2(GRID_WIDTH);
  localparam int YW     = $clog2(GRID_ROWS);
  localparam int ZW     = $clog2(GRID_DEPTH);
  localparam int QW     = 51;
  localparam int IW     = 36;

  localparam logic [QW-1:0]     KX = QW'((GRID_WIDTH - 1) * 32768);
  localparam logic [QW-1:0]     KY = QW'((GRID_ROWS - 1) * 32768);
  localparam logic [QW-1:0]     KZ = QW'((GRID_DEPTH - 1) * 32768);
  localparam logic [ADDR_W-1:0] W_A = ADDR_W'(GRID_WIDTH);
  localparam logic [ADDR_W-1:0] H_A = ADDR_W'(GRID_ROWS);
  localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(NVOX - 1);
  localparam logic [YW-1:0]     Y_LAST = YW'(GRID_ROWS - 1);
  localparam logic [ZW-1:0]     Z_LAST = ZW'(GRID_DEPTH - 1);
  localparam logic [12:0]       W13 = 13'(GRID_WIDTH);
  localparam logic [12:0]       H13 = 13'(GRID_ROWS);
  localparam logic [IW:0]       WX37 = (IW+1)'(GRID_WIDTH);

  state_t state, state_next;

  // configuration
  logic [31:0] center_x, center_y, center_z;
  logic [31:0] scale_x, scale_y, scale_z;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      scale_x  <= 32'd65536;
      scale_y  <= 32'd65536;
      scale_z  <= 32'd65536;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_CENTER_X: center_x <= pwdata;
        REG_CENTER_Y: center_y <= pwdata;
        REG_CENTER_Z: center_z <= pwdata;
        REG_SCALE_X:  scale_x  <= pwdata;
        REG_SCALE_Y:  scale_y  <= pwdata;
        REG_SCALE_Z:  scale_z  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_CENTER_X: prdata = center_x;
      REG_CENTER_Y: prdata = center_y;
      REG_CENTER_Z: prdata = center_z;
      REG_SCALE_X:  prdata = scale_x;
      REG_SCALE_Y:  prdata = scale_y;
      REG_SCALE_Z:  prdata = scale_z;
      default:      prdata = '0;
    endcase
  end

  // datapath registers
  req_t              req_q;
  logic [ADDR_W-1:0] clr;
  logic [1:0]        axis;
  logic [47:0]       norm;
  logic [32:0]       d_mag;
  logic              d_neg;
  logic [48:0]       prod_lo, prod_hi;
  logic [64:0]       full;
  logic [15:0]       tx, ty, tz;
  logic [IW-1:0]     i0x;
  logic [YW-1:0]     jy0;
  logic [ZW-1:0]     jz0;
  logic [2:0]        k;
  logic [16:0]       wzy, w;
  logic [40:0]       pl, ph;
  logic [48:0]       addv;
  logic              x_ok;
  logic [ADDR_W-1:0] addr;
  logic [ZW-1:0]     zc;
  logic [35:0]       sum;
  logic [3:0]        written;
  logic              sat;

  // per-axis selection
  logic [31:0]    pos_a, ctr_a, scl_a;
  logic [QW-1:0]  k_a;
  logic [32:0]    d_a;
  logic [QW-1:0]  q_a;
  logic [QW-1:0]  a_ext;

  always_comb begin
    case (axis)
      AXIS_X:  begin pos_a = req_q.pos_x; ctr_a = center_x; scl_a = scale_x; k_a = KX; end
      AXIS_Y:  begin pos_a = req_q.pos_y; ctr_a = center_y; scl_a = scale_y; k_a = KY; end
      default: begin pos_a = req_q.pos_z; ctr_a = center_z; scl_a = scale_z; k_a = KZ; end
    endcase
  end

  assign d_a   = {pos_a[31], pos_a} - {ctr_a[31], ctr_a};
  assign a_ext = {2'b00, full[64:16]};
  // floor((pos-center)*scale / 2^16) + GRID/2 - 1/2, negative side via ~a + !frac
  assign q_a = d_neg ? (~a_ext + k_a + QW'(~|full[15:0])) : (a_ext + k_a);

  // wrap units for y and z
  logic          wy_start, wz_start, wy_done, wz_done;
  logic [YW-1:0] wy_res;
  logic [ZW-1:0] wz_res;
  logic [IW-1:0] i0_a;

  assign i0_a = {q_a[QW-1], q_a[QW-1:16]};

  ccpd_wrap #(.MODULUS(GRID_ROWS), .IN_W(IW)) u_wrap_y (
    .clk(clk), .rst(rst), .start(wy_start), .value(i0_a),
    .done(wy_done), .result(wy_res)
  );

  ccpd_wrap #(.MODULUS(GRID_DEPTH), .IN_W(IW)) u_wrap_z (
    .clk(clk), .rst(rst), .start(wz_start), .value(i0_a),
    .done(wz_done), .result(wz_res)
  );

  // voxel k neighbours and weights
  logic [16:0]       wx_k, wy_k, wz_k;
  logic [YW-1:0]     jy_k;
  logic [ZW-1:0]     jz_k;
  logic [IW:0]       jx_k;
  logic [33:0]       wzy_p, w_p;
  logic [ADDR_W-1:0] vox_addr, col_addr;

  assign wx_k = k[0] ? {1'b0, tx} : 17'h10000 - {1'b0, tx};
  assign wy_k = k[1] ? {1'b0, ty} : 17'h10000 - {1'b0, ty};
  assign wz_k = k[2] ? {1'b0, tz} : 17'h10000 - {1'b0, tz};
  assign jy_k = (k[1] == 1'b0) ? jy0 : ((jy0 == Y_LAST) ? '0 : jy0 + 1'b1);
  assign jz_k = (k[2] == 1'b0) ? jz0 : ((jz0 == Z_LAST) ? '0 : jz0 + 1'b1);
  assign jx_k = {i0x[IW-1], i0x} + (IW+1)'(k[0]);
  assign wzy_p = wz_k * wy_k;
  assign w_p   = wzy * wx_k;
  assign vox_addr = (ADDR_W'(jz_k) * H_A + ADDR_W'(jy_k)) * W_A + ADDR_W'(jx_k[XW-1:0]);
  assign col_addr = (ADDR_W'(zc) * H_A + ADDR_W'(req_q.pixel_row)) * W_A
                    + ADDR_W'(req_q.pixel_col);

  // memory
  mem_ctl_t          mctl;
  logic [ADDR_W-1:0] m_wr_addr, m_rd_addr;
  logic [31:0]       m_wr_data, m_rd_data;
  logic [49:0]       nv;
  logic [36:0]       sum_add;

  assign nv      = {18'd0, m_rd_data} + {1'b0, addv};
  assign sum_add = {1'b0, sum} + {5'd0, m_rd_data};

  ccpd_mem #(.DEPTH(NVOX), .ADDR_W(ADDR_W)) u_mem (
    .clk(clk), .ctl(mctl), .wr_addr(m_wr_addr), .wr_data(m_wr_data),
    .rd_addr(m_rd_addr), .rd_data(m_rd_data)
  );

  logic accept, in_range;
  assign accept   = start & ~busy;
  assign in_range = ({7'd0, req.pixel_col} < W13) && ({7'd0, req.pixel_row} < H13);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (clr == LAST_A) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (req.opcode == OP_DEPOSIT) state_next = ST_NORM;
          else if (in_range)            state_next = ST_RD_ISSUE;
          else                          state_next = ST_DONE;
        end
      end
      ST_NORM:      state_next = ST_DIFF;
      ST_DIFF:      state_next = ST_MLO;
      ST_MLO:       state_next = ST_MHI;
      ST_MHI:       state_next = ST_SUM;
      ST_SUM:       state_next = ST_QUANT;
      ST_QUANT:     state_next = (axis == AXIS_Z) ? ST_WRAP_WAIT : ST_DIFF;
      ST_WRAP_WAIT: if (wz_done) state_next = ST_VW1;
      ST_VW1:       state_next = ST_VW2;
      ST_VW2:       state_next = ST_VA1;
      ST_VA1:       state_next = ST_VA2;
      ST_VA2:       state_next = ST_VA3;
      ST_VA3:       state_next = ST_VWR;
      ST_VWR:       state_next = (k == 3'd7) ? ST_DONE : ST_VW1;
      ST_RD_ISSUE:  state_next = ST_RD_ACC;
      ST_RD_ACC:    state_next = (zc == Z_LAST) ? ST_DONE : ST_RD_ISSUE;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    busy         = (state != ST_IDLE);
    result_valid = (state == ST_DONE);
    mctl         = '0;
    m_wr_addr    = addr;
    m_wr_data    = '0;
    m_rd_addr    = addr;
    wy_start     = 1'b0;
    wz_start     = 1'b0;
    case (state)
      ST_CLEAR: begin
        mctl.wr_en = 1'b1;
        m_wr_addr  = clr;
      end
      ST_QUANT: begin
        wy_start = (axis == AXIS_Y);
        wz_start = (axis == AXIS_Z);
      end
      ST_VA1:      mctl.rd_en = x_ok;
      ST_VWR: begin
        mctl.wr_en = x_ok;
        m_wr_data  = (nv >= {18'd0, VOX_MAX}) ? VOX_MAX : nv[31:0];
      end
      ST_RD_ISSUE: begin
        mctl.rd_en = 1'b1;
        m_rd_addr  = col_addr;
      end
      ST_RD_ACC:   mctl.wr_en = 1'b1;
      default: ;
    endcase
  end

  assign result.column_sum     = sum;
  assign result.voxels_written = written;
  assign result.saturated      = sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wy_done) jy0 <= wy_res;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          req_q   <= req;
          sum     <= '0;
          written <= '0;
          sat     <= 1'b0;
          axis    <= AXIS_X;
          k       <= '0;
          zc      <= '0;
        end
      end
      ST_NORM:  norm <= 48'((64'(scale_x) * 64'(scale_y)) >> 16);
      ST_DIFF: begin
        d_neg <= d_a[32];
        d_mag <= d_a[32] ? (~d_a + 1'b1) : d_a;
      end
      ST_MLO:   prod_lo <= d_mag * scl_a[15:0];
      ST_MHI:   prod_hi <= d_mag * scl_a[31:16];
      ST_SUM:   full <= {16'd0, prod_lo} + {prod_hi, 16'd0};
      ST_QUANT: begin
        case (axis)
          AXIS_X:  begin tx <= q_a[15:0]; i0x <= i0_a; end
          AXIS_Y:  ty <= q_a[15:0];
          default: tz <= q_a[15:0];
        endcase
        axis <= axis + 1'b1;
      end
      ST_WRAP_WAIT: if (wz_done) jz0 <= wz_res;
      ST_VW1: begin
        wzy  <= wzy_p[32:16];
        x_ok <= ~jx_k[IW] && (jx_k < WX37);
        addr <= vox_addr;
      end
      ST_VW2: w  <= w_p[32:16];
      ST_VA1: pl <= w * norm[23:0];
      ST_VA2: ph <= w * norm[47:24];
      ST_VA3: addv <= 49'(({24'd0, pl} + {ph, 24'd0}) >> 16);
      ST_VWR: begin
        if (x_ok) begin
          written <= written + 1'b1;
          if (nv >= {18'd0, VOX_MAX}) sat <= 1'b1;
        end
        k <= k + 1'b1;
      end
      ST_RD_ISSUE: addr <= col_addr;
      ST_RD_ACC: begin
        sum <= (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[35:0];
        zc  <= zc + 1'b1;
      end
      default: ;
    endcase
  end

endmodule
